// ----- sv/bpcs_pkg.sv -----
// shared constants of the partition cost scorer
package bpcs_pkg;

  localparam int CNT_W  = 24;
  localparam int DIST_W = 32;
  localparam int Q_W    = 32;
  localparam int EPS_W  = 31;
  localparam int SF_W   = 8;
  localparam int HALF_W = 16;
  localparam int KM_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_SEG   = 2'd0;
  localparam logic [1:0] REQ_BLOCK = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;
  localparam logic [1:0] REQ_ROUND = 2'd3;

  localparam logic [2:0] REL_COLLINEAR = 3'd0;
  localparam logic [2:0] REL_RIGHT     = 3'd1;
  localparam logic [2:0] REL_RIGHT_INT = 3'd2;
  localparam logic [2:0] REL_LEFT      = 3'd3;
  localparam logic [2:0] REL_LEFT_INT  = 3'd4;
  localparam logic [2:0] REL_INTERSECT = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_EPS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_EPS     = 2'd2;

  localparam logic [SF_W-1:0]  SF_RESET  = 8'd7;
  localparam logic [EPS_W-1:0] SE_RESET  = 31'd262144;
  localparam logic [EPS_W-1:0] DE_RESET  = 31'd512;

  localparam logic [7:0] K_RIGHT   = 8'd100;
  localparam logic [7:0] K_LEFT    = 8'd70;
  localparam logic [7:0] K_IFFY    = 8'd140;
  localparam logic [7:0] K_SPLIT   = 8'd100;
  localparam logic [7:0] K_MAP_IMB = 8'd100;
  localparam logic [7:0] K_PRT_IMB = 8'd50;
  localparam logic [7:0] K_SLOPE   = 8'd25;

endpackage

// ----- sv/bpcs_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle, saturating quotient
module bpcs_divider #(
  parameter int NUM_W = 47
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [bpcs_pkg::Q_W-1:0]  den,
  output logic                      done,
  output logic [bpcs_pkg::Q_W-1:0]  quo
);

  localparam int QW = bpcs_pkg::Q_W;

  logic          busy;
  logic [4:0]    step;
  logic [QW-1:0] rem;
  logic [QW-1:0] nsh;
  logic [QW-1:0] den_r;
  logic [QW:0]   trial;
  logic [QW:0]   diff;
  logic          ge;
  logic          ovf;

  // quotient would need more than 32 bits
  assign ovf   = QW'(num[NUM_W-1:QW]) >= den;
  assign trial = {rem, nsh[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      den_r <= den;
      step  <= '0;
      if (den == '0 || ovf) begin
        quo  <= '1;
        done <= 1'b1;
        busy <= 1'b0;
      end else begin
        rem  <= QW'(num[NUM_W-1:QW]);
        nsh  <= num[QW-1:0];
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem  <= ge ? diff[QW-1:0] : trial[QW-1:0];
      nsh  <= {nsh[QW-2:0], 1'b0};
      quo  <= {quo[QW-2:0], ge};
      step <= step + 5'd1;
      if (step == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(busy && start))
    else $error("divider restarted while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

  a_start_answer: assert property (@(posedge clk) disable iff (rst)
    start |=> busy || done)
    else $error("divider ignored a start");

endmodule

// ----- sv/bsp_partition_cost_scorer_unit.sv -----
// top level of the bsp partition cost scorer
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | req_type .. candidate_id
//  res     | out       | res_valid/stall   | result_kind .. right_part
//  cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// a segment item without surcharge ends in S_SEG; one with a near-miss or
// near-edge surcharge goes on to the shared radix-2 divider, then
// square, two partial products and the saturating add
// end of candidate runs S_END1..S_END4 then S_EMIT, end of round only S_EMIT; S_EMIT waits out a res stall
// reset clears the accumulators and the best-so-far, config goes to defaults
// segment and block items are taken while a result still waits on res
module bsp_partition_cost_scorer_unit #(
  parameter int ID_WIDTH  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // request channel
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            req_type,
  input  logic [2:0]                            relation,
  input  logic signed [bpcs_pkg::DIST_W-1:0]    from_dist,
  input  logic signed [bpcs_pkg::DIST_W-1:0]    to_dist,
  input  logic                                  on_map_side,
  input  logic                                  opposite_dir,
  input  logic                                  block_on_left,
  input  logic [bpcs_pkg::HALF_W-1:0]           map_count,
  input  logic [bpcs_pkg::HALF_W-1:0]           part_count,
  input  logic                                  axis_aligned,
  input  logic [bpcs_pkg::HALF_W-1:0]           candidate_id,
  // result channel
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic                                  result_kind,
  output logic [bpcs_pkg::HALF_W-1:0]           result_id,
  output logic                                  suitable,
  output logic signed [31:0]                    total_cost,
  output logic [bpcs_pkg::CNT_W-1:0]            split_count,
  output logic [bpcs_pkg::CNT_W-1:0]            iffy_count,
  output logic [bpcs_pkg::CNT_W-1:0]            near_miss_count,
  output logic [bpcs_pkg::CNT_W-1:0]            left_map,
  output logic [bpcs_pkg::CNT_W-1:0]            right_map,
  output logic [bpcs_pkg::CNT_W-1:0]            left_part,
  output logic [bpcs_pkg::CNT_W-1:0]            right_part,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bpcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                           cfg_data
);

  localparam int CW    = bpcs_pkg::CNT_W;
  localparam int QW    = bpcs_pkg::Q_W;
  localparam int KW    = bpcs_pkg::KM_W;
  localparam int TWO_F = 2 * FRAC_BITS;
  localparam int NUM_W = bpcs_pkg::EPS_W + FRAC_BITS;
  localparam int SW    = 60;
  localparam int IDK   = (ID_WIDTH < bpcs_pkg::HALF_W) ? ID_WIDTH : bpcs_pkg::HALF_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SEG, S_DIV, S_SQR, S_MH, S_ML, S_ACC,
    S_END1, S_END2, S_END3, S_END4, S_EMIT
  } state_t;

  state_t state;

  // config
  logic [bpcs_pkg::SF_W-1:0]  sf;
  logic [bpcs_pkg::EPS_W-1:0] se;
  logic [bpcs_pkg::EPS_W-1:0] de;

  // latched item
  logic [1:0]          it_type;
  logic [2:0]          it_rel;
  logic signed [31:0]  it_f;
  logic signed [31:0]  it_t;
  logic                it_map;
  logic                it_opp;
  logic                it_left;
  logic [15:0]         it_mcnt;
  logic [15:0]         it_pcnt;
  logic                it_axis;
  logic [ID_WIDTH-1:0] it_id;

  // accumulators and best
  logic signed [31:0]  acc;
  logic [CW-1:0] c_split, c_iffy, c_near, c_lmap, c_rmap, c_lpart, c_rpart;
  logic signed [31:0]  best_total;
  logic [ID_WIDTH-1:0] best_id;
  logic                best_valid;
  logic                ok_r;

  // surcharge datapath
  logic [KW-1:0]       kmul;
  logic [QW-1:0]       q_r;
  logic [63:0]         q2_r;
  logic                neg_r;
  logic [TWO_F-1:0]    mlo_r;
  logic [56:0]         p_hi;
  logic [KW-1:0]       p_lo;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [SW-1:0] b);
    logic signed [SW-1:0] v;
    v = SW'(a) + b;
    if (v > SW'(64'sd2147483647)) return 32'sh7FFFFFFF;
    if (v < -SW'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [CW-1:0] cnt_add(input logic [CW-1:0] c,
                                            input logic [15:0] n);
    logic [CW:0] v;
    v = {1'b0, c} + (CW + 1)'(n);
    return v[CW] ? '1 : v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // segment geometry
  logic signed [32:0] f33, t33, se33, de33, af, at;
  logic signed [32:0] mx, mn, seg_d;
  logic               r_skip, l_skip, iffy, need_sur;
  logic [QW-1:0]      den;
  logic [NUM_W-1:0]   num;
  logic               div_start, div_done;
  logic [QW-1:0]      div_q;

  always_comb begin
    f33  = 33'(it_f);
    t33  = 33'(it_t);
    se33 = {2'b00, se};
    de33 = {2'b00, de};
    mx   = (f33 > t33) ? f33 : t33;
    mn   = (f33 < t33) ? f33 : t33;
    af   = f33[32] ? -f33 : f33;
    at   = t33[32] ? -t33 : t33;
    r_skip = (f33 >= se33 && t33 >= se33) || (f33 <= de33 && t33 >= se33) ||
             (t33 <= de33 && f33 >= se33);
    l_skip = (f33 <= -se33 && t33 <= -se33) || (f33 >= -de33 && t33 <= -se33) ||
             (t33 >= -de33 && f33 <= -se33);
    iffy   = af < se33 || at < se33;
    seg_d    = '0;
    need_sur = 1'b0;
    case (it_rel)
      bpcs_pkg::REL_RIGHT: begin
        need_sur = !r_skip;
        seg_d    = (f33 <= de33 || t33 <= de33) ? mx : mn;
      end
      bpcs_pkg::REL_LEFT: begin
        need_sur = !l_skip;
        seg_d    = (f33 >= -de33 || t33 >= -de33) ? -mn : -mx;
      end
      bpcs_pkg::REL_INTERSECT: begin
        need_sur = iffy;
        seg_d    = (af < at) ? af : at;
      end
      default: ;
    endcase
    // non-positive distance saturates through a zero divisor
    den = (seg_d > 33'sd0) ? seg_d[QW-1:0] : '0;
    num = {se, FRAC_BITS'(0)};
    div_start = (state == S_SEG) && (it_type == bpcs_pkg::REQ_SEG) && need_sur;
  end

  bpcs_divider #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  // |q^2 - 1.0| split into whole and fraction parts
  logic [63:0] one_c, m_c, hi_c;
  logic [40:0] hic;
  logic        neg_c;
  logic [TWO_F+KW-1:0] lo_prod;
  logic [57:0]         r_c;

  always_comb begin
    one_c = 64'd1 << TWO_F;
    neg_c = q2_r < one_c;
    m_c   = neg_c ? one_c - q2_r : q2_r - one_c;
    hi_c  = m_c >> TWO_F;
    hic   = (hi_c > (64'd1 << 40)) ? {1'b1, 40'd0} : hi_c[40:0];
    lo_prod = (TWO_F + KW)'(mlo_r) * (TWO_F + KW)'(kmul);
    r_c   = 58'(p_hi) + 58'(p_lo);
  end

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      sf         <= bpcs_pkg::SF_RESET;
      se         <= bpcs_pkg::SE_RESET;
      de         <= bpcs_pkg::DE_RESET;
      acc        <= '0;
      c_split    <= '0;
      c_iffy     <= '0;
      c_near     <= '0;
      c_lmap     <= '0;
      c_rmap     <= '0;
      c_lpart    <= '0;
      c_rpart    <= '0;
      best_total <= '0;
      best_id    <= '0;
      best_valid <= 1'b0;
      ok_r       <= 1'b0;
    end else begin
      // result taken and no new one loaded in this cycle
      if (res_valid && !res_stall && state != S_EMIT) res_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bpcs_pkg::CFG_SPLIT_FACTOR: sf <= cfg_data[bpcs_pkg::SF_W-1:0];
          bpcs_pkg::CFG_SHORT_EPS:    se <= cfg_data[bpcs_pkg::EPS_W-1:0];
          bpcs_pkg::CFG_DIST_EPS:     de <= cfg_data[bpcs_pkg::EPS_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            it_type <= req_type;
            it_rel  <= relation;
            it_f    <= from_dist;
            it_t    <= to_dist;
            it_map  <= on_map_side;
            it_opp  <= opposite_dir;
            it_left <= block_on_left;
            it_mcnt <= map_count;
            it_pcnt <= part_count;
            it_axis <= axis_aligned;
            it_id   <= ID_WIDTH'(candidate_id[IDK-1:0]);
            unique case (req_type)
              bpcs_pkg::REQ_SEG, bpcs_pkg::REQ_BLOCK: state <= S_SEG;
              bpcs_pkg::REQ_END:   state <= S_END1;
              bpcs_pkg::REQ_ROUND: state <= S_EMIT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SEG: begin
          state <= S_IDLE;
          if (it_type == bpcs_pkg::REQ_BLOCK) begin
            if (it_left) begin
              c_lmap  <= cnt_add(c_lmap, it_mcnt);
              c_lpart <= cnt_add(c_lpart, it_pcnt);
            end else begin
              c_rmap  <= cnt_add(c_rmap, it_mcnt);
              c_rpart <= cnt_add(c_rpart, it_pcnt);
            end
          end else begin
            case (it_rel)
              bpcs_pkg::REL_COLLINEAR: begin
                if (it_opp) begin
                  if (it_map) c_lmap <= cnt_add(c_lmap, 16'd1);
                  else c_lpart <= cnt_add(c_lpart, 16'd1);
                end else begin
                  if (it_map) c_rmap <= cnt_add(c_rmap, 16'd1);
                  else c_rpart <= cnt_add(c_rpart, 16'd1);
                end
              end
              bpcs_pkg::REL_RIGHT, bpcs_pkg::REL_RIGHT_INT: begin
                if (it_map) c_rmap <= cnt_add(c_rmap, 16'd1);
                else c_rpart <= cnt_add(c_rpart, 16'd1);
                if (need_sur) begin
                  c_near <= cnt_add(c_near, 16'd1);
                  kmul   <= KW'(sf) * KW'(bpcs_pkg::K_RIGHT);
                  state  <= S_DIV;
                end
              end
              bpcs_pkg::REL_LEFT, bpcs_pkg::REL_LEFT_INT: begin
                if (it_map) c_lmap <= cnt_add(c_lmap, 16'd1);
                else c_lpart <= cnt_add(c_lpart, 16'd1);
                if (need_sur) begin
                  c_near <= cnt_add(c_near, 16'd1);
                  kmul   <= KW'(sf) * KW'(bpcs_pkg::K_LEFT);
                  state  <= S_DIV;
                end
              end
              bpcs_pkg::REL_INTERSECT: begin
                c_split <= cnt_add(c_split, 16'd1);
                acc <= sat_add(acc, SW'(KW'(sf) * KW'(bpcs_pkg::K_SPLIT)));
                if (need_sur) begin
                  c_iffy <= cnt_add(c_iffy, 16'd1);
                  kmul   <= KW'(sf) * KW'(bpcs_pkg::K_IFFY);
                  state  <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            q_r   <= div_q;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          q2_r  <= {32'd0, q_r} * {32'd0, q_r};
          state <= S_MH;
        end
        S_MH: begin
          neg_r <= neg_c;
          mlo_r <= m_c[TWO_F-1:0];
          p_hi  <= 57'(hic) * 57'(kmul);
          state <= S_ML;
        end
        S_ML: begin
          p_lo  <= lo_prod[TWO_F+KW-1:TWO_F];
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= sat_add(acc, neg_r ? -SW'(r_c) : SW'(r_c));
          state <= S_IDLE;
        end
        S_END1: begin
          ok_r <= (c_lmap != '0) && (c_rmap != '0);
          if (c_lmap != '0 && c_rmap != '0)
            acc <= sat_add(acc, SW'(absdiff(c_lmap, c_rmap)) * SW'(bpcs_pkg::K_MAP_IMB));
          state <= S_END2;
        end
        S_END2: begin
          if (ok_r)
            acc <= sat_add(acc, SW'(absdiff(c_lpart, c_rpart)) * SW'(bpcs_pkg::K_PRT_IMB));
          state <= S_END3;
        end
        S_END3: begin
          if (ok_r && !it_axis) acc <= sat_add(acc, SW'(bpcs_pkg::K_SLOPE));
          state <= S_END4;
        end
        S_END4: begin
          // first candidate wins on ties
          if (ok_r && (!best_valid || acc < best_total)) begin
            best_valid <= 1'b1;
            best_total <= acc;
            best_id    <= it_id;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            if (it_type == bpcs_pkg::REQ_ROUND) begin
              result_kind     <= 1'b1;
              result_id       <= best_valid ? 16'(best_id) : '0;
              suitable        <= best_valid;
              total_cost      <= best_valid ? best_total : '0;
              split_count     <= '0;
              iffy_count      <= '0;
              near_miss_count <= '0;
              left_map        <= '0;
              right_map       <= '0;
              left_part       <= '0;
              right_part      <= '0;
              best_valid      <= 1'b0;
              best_total      <= '0;
              best_id         <= '0;
            end else begin
              result_kind     <= 1'b0;
              result_id       <= 16'(it_id);
              suitable        <= ok_r;
              total_cost      <= acc;
              split_count     <= c_split;
              iffy_count      <= c_iffy;
              near_miss_count <= c_near;
              left_map        <= c_lmap;
              right_map       <= c_rmap;
              left_part       <= c_lpart;
              right_part      <= c_rpart;
            end
            acc     <= '0;
            c_split <= '0;
            c_iffy  <= '0;
            c_near  <= '0;
            c_lmap  <= '0;
            c_rmap  <= '0;
            c_lpart <= '0;
            c_rpart <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a suitable score always has map segments on both sides
  a_suitable_sides: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result_kind && suitable |-> left_map != '0 && right_map != '0)
    else $error("suitable candidate without map segments on a side");

  // round results carry no counts
  a_round_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_kind |-> split_count == '0 && left_map == '0 && right_part == '0)
    else $error("round result with counts");

  // no best means zero id and total
  a_round_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_kind && !suitable |-> total_cost == '0 && result_id == '0)
    else $error("empty round result not zero");

  // the divider only answers while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide step");

  // best is forgotten once the round result is loaded
  a_round_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && it_type == bpcs_pkg::REQ_ROUND && (!res_valid || !res_stall)
    |=> !best_valid && acc == '0)
    else $error("round state not cleared");

endmodule

// ----- test/bsp_partition_cost_scorer_unit_tb.sv -----
// testbench for the bsp partition cost scorer: directed and random items, predicted scores
`timescale 1ns / 1ps

module bsp_partition_cost_scorer_unit_tb;

  localparam int F = 16;

  typedef struct packed {
    logic        kind;
    logic [15:0] id;
    logic        ok;
    logic [31:0] total;
    logic [23:0] splits, iffy, near, lmap, rmap, lpart, rpart;
  } score_t;

  // ---------------------------------------------------------------- checker
  class score_board;
    score_t pending[$];
    int     errors;

    function void note(score_t s);
      pending.push_back(s);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check(score_t g);
      score_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 32'(g.id), 32'd0);
        return;
      end
      e = pending.pop_front();
      if (g.kind != e.kind) report("result_kind", 32'(g.kind), 32'(e.kind));
      if (g.id != e.id) report("result_id", 32'(g.id), 32'(e.id));
      if (g.ok != e.ok) report("suitable", 32'(g.ok), 32'(e.ok));
      if (g.total != e.total) report("total_cost", g.total, e.total);
      if (g.splits != e.splits) report("split_count", 32'(g.splits), 32'(e.splits));
      if (g.iffy != e.iffy) report("iffy_count", 32'(g.iffy), 32'(e.iffy));
      if (g.near != e.near) report("near_miss_count", 32'(g.near), 32'(e.near));
      if (g.lmap != e.lmap) report("left_map", 32'(g.lmap), 32'(e.lmap));
      if (g.rmap != e.rmap) report("right_map", 32'(g.rmap), 32'(e.rmap));
      if (g.lpart != e.lpart) report("left_part", 32'(g.lpart), 32'(e.lpart));
      if (g.rpart != e.rpart) report("right_part", 32'(g.rpart), 32'(e.rpart));
    endtask
  endclass

  // ---------------------------------------------------------------- dut
  logic clk = 0, rst = 1;
  logic req_valid = 0, req_stall;
  logic [1:0] req_type = 0;
  logic [2:0] relation = 0;
  logic signed [31:0] from_dist = 0, to_dist = 0;
  logic on_map_side = 0, opposite_dir = 0, block_on_left = 0, axis_aligned = 0;
  logic [15:0] map_count = 0, part_count = 0, candidate_id = 0;
  logic res_valid, res_stall = 0;
  logic result_kind, suitable;
  logic [15:0] result_id;
  logic signed [31:0] total_cost;
  logic [23:0] split_count, iffy_count, near_miss_count;
  logic [23:0] left_map, right_map, left_part, right_part;
  logic cfg_valid = 0, cfg_ready;
  logic [bpcs_pkg::CFG_IDX_W-1:0] cfg_index = bpcs_pkg::CFG_SPLIT_FACTOR;
  logic [31:0] cfg_data = 0;

  bsp_partition_cost_scorer_unit dut (.*);

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor state
  logic [7:0]  pf_factor;
  logic [30:0] pf_short, pf_dist;
  logic signed [31:0] run_total, best_total;
  logic [23:0] tally [7];   // splits, iffy, near, lmap, rmap, lpart, rpart
  logic [15:0] best_id;
  logic        best_ok;

  score_board sb;
  bit  idle_en = 1;      // random gaps on both sides
  int  cycles = 0;
  int  n_items = 0;

  function automatic logic signed [31:0] sat32(logic signed [31:0] a, longint b);
    longint v;
    v = longint'(a) + b;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic void bump(int i, longint n);
    longint v;
    v = longint'(tally[i]) + n;
    tally[i] = (v > 24'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  // q = (short_eps << F) / d, saturating at 32 bits
  function automatic logic [63:0] edge_ratio(longint d);
    logic [63:0] q;
    if (d <= 0) return 64'hFFFFFFFF;
    q = ({33'd0, pf_short} << F) / d;
    return (q > 64'hFFFFFFFF) ? 64'hFFFFFFFF : q;
  endfunction

  // k * (q*q - 1.0) truncated toward zero in 128 bits, whole part clamped at 2^40
  function automatic longint penalty(logic [63:0] q, logic [63:0] k);
    logic [63:0] q2, one, m, hi, lo;
    logic [127:0] r;
    bit neg;
    q2 = q * q;
    one = 64'd1 << (2 * F);
    neg = q2 < one;
    m = neg ? one - q2 : q2 - one;
    hi = m >> (2 * F);
    lo = m & (one - 1);
    if (hi > (64'd1 << 40)) hi = 64'd1 << 40;
    r = 128'(hi) * k + ((128'(lo) * k) >> (2 * F));
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic void side(bit left, bit map);
    if (left) bump(map ? 3 : 5, 1);
    else bump(map ? 4 : 6, 1);
  endfunction

  function automatic void score_segment(logic [2:0] rel, longint f, longint t, bit map, bit opp);
    longint se, de, d, af, at;
    se = pf_short;
    de = pf_dist;
    case (rel)
      bpcs_pkg::REL_COLLINEAR: side(opp, map);
      bpcs_pkg::REL_RIGHT, bpcs_pkg::REL_RIGHT_INT: begin
        side(0, map);
        if (rel == bpcs_pkg::REL_RIGHT &&
            !((f >= se && t >= se) || (f <= de && t >= se) || (t <= de && f >= se))) begin
          if (f <= de || t <= de) d = f > t ? f : t;
          else d = f < t ? f : t;
          bump(2, 1);
          run_total = sat32(run_total, penalty(edge_ratio(d), 100 * pf_factor));
        end
      end
      bpcs_pkg::REL_LEFT, bpcs_pkg::REL_LEFT_INT: begin
        side(1, map);
        if (rel == bpcs_pkg::REL_LEFT &&
            !((f <= -se && t <= -se) || (f >= -de && t <= -se) ||
              (t >= -de && f <= -se))) begin
          if (f >= -de || t >= -de) d = -(f < t ? f : t);
          else d = -(f > t ? f : t);
          bump(2, 1);
          run_total = sat32(run_total, penalty(edge_ratio(d), 70 * pf_factor));
        end
      end
      bpcs_pkg::REL_INTERSECT: begin
        bump(0, 1);
        run_total = sat32(run_total, 100 * pf_factor);
        af = f < 0 ? -f : f;
        at = t < 0 ? -t : t;
        if (af < se || at < se) begin
          d = af < at ? af : at;
          bump(1, 1);
          run_total = sat32(run_total, penalty(edge_ratio(d), 140 * pf_factor));
        end
      end
      default: ;   // unknown relation codes are ignored
    endcase
  endfunction

  function automatic longint gap(logic [23:0] a, logic [23:0] b);
    return a > b ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic void clear_run();
    run_total = 0;
    foreach (tally[i]) tally[i] = 0;
  endfunction

  // note one accepted request in the predictor
  function automatic void predict_request();
    score_t s;
    s = '0;
    case (req_type)
      bpcs_pkg::REQ_SEG:
        score_segment(relation, from_dist, to_dist, on_map_side, opposite_dir);
      bpcs_pkg::REQ_BLOCK: begin
        bump(block_on_left ? 3 : 4, map_count);
        bump(block_on_left ? 5 : 6, part_count);
      end
      bpcs_pkg::REQ_END: begin
        s.ok = tally[3] != 0 && tally[4] != 0;
        if (s.ok) begin
          run_total = sat32(run_total, 100 * gap(tally[3], tally[4]));
          run_total = sat32(run_total, 50 * gap(tally[5], tally[6]));
          if (!axis_aligned) run_total = sat32(run_total, 25);
          if (!best_ok || run_total < best_total) begin
            best_ok = 1;
            best_total = run_total;
            best_id = candidate_id;
          end
        end
        s.id = candidate_id;
        s.total = run_total;
        {s.splits, s.iffy, s.near} = {tally[0], tally[1], tally[2]};
        {s.lmap, s.rmap, s.lpart, s.rpart} = {tally[3], tally[4], tally[5], tally[6]};
        clear_run();
        sb.note(s);
      end
      default: begin
        s.kind = 1;
        s.ok = best_ok;
        s.id = best_ok ? best_id : '0;
        s.total = best_ok ? best_total : '0;
        best_ok = 0;
        best_total = 0;
        best_id = 0;
        clear_run();
        sb.note(s);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- result side
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check({result_kind, result_id, suitable, total_cost, split_count, iffy_count,
                near_miss_count, left_map, right_map, left_part, right_part});
    res_stall <= idle_en && ($urandom_range(99) < 30);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // valid stays up after acceptance only when the next item follows at once
  task automatic send(logic [1:0] rt, logic [2:0] rel, logic [31:0] f, logic [31:0] t,
                      bit map, bit opp, bit lft, logic [15:0] mc, logic [15:0] pc,
                      bit ax, logic [15:0] id);
    while (idle_en && $urandom_range(99) < 30) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req_type <= rt; relation <= rel; from_dist <= f; to_dist <= t;
    on_map_side <= map; opposite_dir <= opp; block_on_left <= lft;
    map_count <= mc; part_count <= pc; axis_aligned <= ax; candidate_id <= id;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_request();
    n_items++;
  endtask

  task automatic seg(logic [2:0] rel, logic [31:0] f, logic [31:0] t, bit map, bit opp);
    send(bpcs_pkg::REQ_SEG, rel, f, t, map, opp, $urandom, $urandom, $urandom, $urandom,
         $urandom);
  endtask

  task automatic block(bit lft, logic [15:0] mc, logic [15:0] pc);
    send(bpcs_pkg::REQ_BLOCK, $urandom, $urandom, $urandom, $urandom, $urandom, lft, mc, pc,
         $urandom, $urandom);
  endtask

  task automatic finish_cand(bit ax, logic [15:0] id);
    send(bpcs_pkg::REQ_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, ax, id);
  endtask

  task automatic finish_round();
    send(bpcs_pkg::REQ_ROUND, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom);
  endtask

  // wait for every expected result, then for the worst segment latency
  task automatic drain();
    req_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [bpcs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      bpcs_pkg::CFG_SPLIT_FACTOR: pf_factor = v[7:0];
      bpcs_pkg::CFG_SHORT_EPS: pf_short = v[30:0];
      default: pf_dist = v[30:0];
    endcase
    @(posedge clk);
  endtask

  // distance near the line scaled to the short edge or distance threshold, or anywhere
  function automatic logic [31:0] pick_dist();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return $signed($urandom_range(2 * pf_short)) - $signed(pf_short);
    if (r < 8) return $signed($urandom_range(pf_dist + 4)) - 2;
    return $urandom;
  endfunction

  task automatic random_candidate();
    int n;
    n = $urandom_range(12);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        block($urandom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(4),
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(4));
      end else
        seg(($urandom_range(15) == 0) ? $urandom_range(7, 6) : $urandom_range(5),
            pick_dist(), pick_dist(), $urandom_range(3) != 0, $urandom);
    end
    finish_cand($urandom, $urandom);
    if ($urandom_range(5) == 0) finish_round();
  endtask

  task automatic random_phase(int target);
    while (n_items < target) random_candidate();
    finish_round();
    drain();
  endtask

  initial begin
    sb = new();
    pf_factor = bpcs_pkg::SF_RESET;
    pf_short = bpcs_pkg::SE_RESET;
    pf_dist = bpcs_pkg::DE_RESET;
    clear_run();
    best_ok = 0;
    best_total = 0;
    best_id = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: an empty round, each relation, field extremes
    finish_round();
    finish_cand(0, 16'hFFFF);                           // no map segments: unsuitable
    seg(bpcs_pkg::REL_COLLINEAR, 0, 0, 1, 0);
    seg(bpcs_pkg::REL_COLLINEAR, 0, 0, 1, 1);
    seg(bpcs_pkg::REL_RIGHT, 32'h7FFFFFFF, 32'h80000000, 1, 0);  // max and min distances
    seg(bpcs_pkg::REL_RIGHT, 100, 1000, 0, 0);          // near miss with an end on line
    seg(bpcs_pkg::REL_RIGHT_INT, 5, 5, 1, 0);
    seg(bpcs_pkg::REL_LEFT, -100, -1000, 1, 0);
    seg(bpcs_pkg::REL_LEFT, 0, 0, 0, 1);                // zero divisor saturates
    seg(bpcs_pkg::REL_LEFT_INT, -5, -5, 0, 0);
    seg(bpcs_pkg::REL_INTERSECT, 32'h80000000, 32'h7FFFFFFF, 1, 0);
    seg(bpcs_pkg::REL_INTERSECT, 1, -1, 0, 0);          // tiny divisor: surcharge overflow
    seg(3'd6, 1, 1, 1, 1);                               // unknown codes ignored
    seg(3'd7, 1, 1, 1, 1);
    block(1, 16'hFFFF, 16'hFFFF);
    block(0, 16'hFFFF, 0);
    finish_cand(1, 16'h0000);
    seg(bpcs_pkg::REL_RIGHT, 1, 2, 1, 0);
    seg(bpcs_pkg::REL_LEFT, -1, -2, 1, 0);
    finish_cand(0, 16'h1234);
    seg(bpcs_pkg::REL_RIGHT, 1, 2, 1, 0);
    seg(bpcs_pkg::REL_LEFT, -1, -2, 1, 0);
    finish_cand(0, 16'h4321);                            // tie: first one stays best
    finish_round();
    drain();

    // count saturation: many full blocks on one side
    repeat (260) block(1, 16'hFFFF, 16'hFFFF);
    block(0, 1, 0);
    finish_cand(1, 16'hAAAA);
    finish_round();
    drain();

    // random phases under several register settings, extremes included
    random_phase(450);
    write_reg(bpcs_pkg::CFG_SPLIT_FACTOR, 8'hFF);
    write_reg(bpcs_pkg::CFG_SHORT_EPS, 32'h7FFFFFFF);
    write_reg(bpcs_pkg::CFG_DIST_EPS, 32'h7FFFFFFF);
    random_phase(700);
    write_reg(bpcs_pkg::CFG_SPLIT_FACTOR, 0);
    write_reg(bpcs_pkg::CFG_SHORT_EPS, 1);
    write_reg(bpcs_pkg::CFG_DIST_EPS, 1);
    random_phase(900);
    write_reg(bpcs_pkg::CFG_SPLIT_FACTOR, 32'hFFFFFF00 | $urandom_range(255));
    write_reg(bpcs_pkg::CFG_SHORT_EPS, 32'h80000000 | $urandom_range(1 << 20, 1 << 18));
    write_reg(bpcs_pkg::CFG_DIST_EPS, 32'h80000000 | $urandom_range(1 << 12, 1));
    idle_en = 0;                                         // stretch with no gaps
    random_phase(1200);
    idle_en = 1;
    write_reg(bpcs_pkg::CFG_SPLIT_FACTOR, bpcs_pkg::SF_RESET);
    write_reg(bpcs_pkg::CFG_SHORT_EPS, bpcs_pkg::SE_RESET);
    write_reg(bpcs_pkg::CFG_DIST_EPS, bpcs_pkg::DE_RESET);
    random_phase(1750);

    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- bsp_partition_cost_scorer_unit.f -----
sv/bpcs_pkg.sv
sv/bpcs_divider.sv
sv/bsp_partition_cost_scorer_unit.sv
test/bsp_partition_cost_scorer_unit_tb.sv
